### rtl/atilt_pkg.sv
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared types, constants and tables for the accelerometer tilt angle block.
// ----------------------------------------------------------------------------
package atilt_pkg;

  localparam int unsigned Steps   = 20;
  localparam int unsigned CordW   = 40;
  localparam int unsigned AngW    = 26;
  localparam int unsigned Latency = 2 * (Steps + 1) + 1;

  localparam logic [30:0]        GainQ30    = 31'd1768195363;
  localparam logic signed [15:0] RightAngle = 16'sd23040;

  typedef logic signed [15:0]      sample_t;
  typedef logic signed [15:0]      angle_t;
  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0]  ang_acc_t;
  typedef logic [16:0]             mag_t;

  typedef struct packed {
    logic neg;
    logic nzero;
    logic rzero;
  } flags_t;

  function automatic mag_t mag16(input sample_t v);
    mag_t s;
    s = {v[15], v};
    return v[15] ? mag_t'(-s) : s;
  endfunction

  // atan(2^-i) in degrees, 2^-16 degree units
  function automatic ang_acc_t atan_lut(input int unsigned i);
    ang_acc_t r;
    case (i)
      0:       r = 26'sd2949120;
      1:       r = 26'sd1740967;
      2:       r = 26'sd919879;
      3:       r = 26'sd466945;
      4:       r = 26'sd234379;
      5:       r = 26'sd117304;
      6:       r = 26'sd58666;
      7:       r = 26'sd29335;
      8:       r = 26'sd14668;
      9:       r = 26'sd7334;
      10:      r = 26'sd3667;
      11:      r = 26'sd1833;
      12:      r = 26'sd917;
      13:      r = 26'sd458;
      14:      r = 26'sd229;
      15:      r = 26'sd115;
      16:      r = 26'sd57;
      17:      r = 26'sd29;
      18:      r = 26'sd14;
      19:      r = 26'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/atilt_unit.sv
// ----------------------------------------------------------------------------
// atilt_unit
// One tilt angle: pipelined CORDIC root, gain match multiply, pipelined
// CORDIC arctangent and rounding, one step per stage.
// ----------------------------------------------------------------------------
module atilt_unit (
  input  logic              clk_i,
  input  logic              en_i,
  input  atilt_pkg::sample_t num_i,
  input  atilt_pkg::sample_t oth_a_i,
  input  atilt_pkg::sample_t oth_b_i,
  output atilt_pkg::angle_t  angle_o
);
  import atilt_pkg::*;

  cord_t    rx_q [Steps+1];
  cord_t    ry_q [Steps+1];
  cord_t    ax_q [Steps+1];
  cord_t    ay_q [Steps+1];
  ang_acc_t az_q [Steps+1];
  mag_t     nmag_q [Steps+1];
  flags_t   fl_q [2*(Steps+1)];
  angle_t   angle_q;
  logic [47:0] prod;
  ang_acc_t rnd;
  angle_t   mag_r;
  angle_t   angle_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]     <= cord_t'({7'b0, mag16(oth_a_i), 16'b0});
      ry_q[0]     <= cord_t'({7'b0, mag16(oth_b_i), 16'b0});
      nmag_q[0]   <= mag16(num_i);
      fl_q[0].neg   <= num_i[15];
      fl_q[0].nzero <= (num_i == '0);
      fl_q[0].rzero <= (oth_a_i == '0) && (oth_b_i == '0);
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_root
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!ry_q[k][CordW-1]) begin
          rx_q[k+1] <= rx_q[k] + (ry_q[k] >>> k);
          ry_q[k+1] <= ry_q[k] - (rx_q[k] >>> k);
        end else begin
          rx_q[k+1] <= rx_q[k] - (ry_q[k] >>> k);
          ry_q[k+1] <= ry_q[k] + (rx_q[k] >>> k);
        end
        nmag_q[k+1] <= nmag_q[k];
        fl_q[k+1]   <= fl_q[k];
      end
    end
  end

  assign prod = 48'(nmag_q[Steps]) * 48'(GainQ30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q[0]       <= rx_q[Steps];
      ay_q[0]       <= cord_t'({6'b0, prod[47:14]});
      az_q[0]       <= '0;
      fl_q[Steps+1] <= fl_q[Steps];
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_atan
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!ay_q[k][CordW-1]) begin
          ax_q[k+1] <= ax_q[k] + (ay_q[k] >>> k);
          ay_q[k+1] <= ay_q[k] - (ax_q[k] >>> k);
          az_q[k+1] <= az_q[k] + atan_lut(k);
        end else begin
          ax_q[k+1] <= ax_q[k] - (ay_q[k] >>> k);
          ay_q[k+1] <= ay_q[k] + (ax_q[k] >>> k);
          az_q[k+1] <= az_q[k] - atan_lut(k);
        end
        fl_q[Steps+2+k] <= fl_q[Steps+1+k];
      end
    end
  end

  always_comb begin
    rnd = (az_q[Steps] + ang_acc_t'(128)) >>> 8;
    if (rnd[AngW-1]) begin
      mag_r = '0;
    end else if (rnd > ang_acc_t'(RightAngle)) begin
      mag_r = RightAngle;
    end else begin
      mag_r = rnd[15:0];
    end
    if (fl_q[2*Steps+1].nzero) begin
      angle_d = '0;
    end else if (fl_q[2*Steps+1].rzero) begin
      angle_d = fl_q[2*Steps+1].neg ? -RightAngle : RightAngle;
    end else begin
      angle_d = fl_q[2*Steps+1].neg ? -mag_r : mag_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

### rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Pitch, roll and yaw from one raw accelerometer sample triple.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: sample_x_i/y_i/z_i with valid_i, taken when valid_i is
//   high and stall_o is low. Output request: pitch/roll/yaw_angle_o with
//   valid_o, taken when valid_o is high and stall_i is low. Angles are in
//   1/256 degree, within +-90 degrees.
//   The path has one input register, 20 root CORDIC stages, a gain multiply
//   stage, 20 arctangent CORDIC stages and the output register.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the one-step-per-stage CORDIC pipelines of the three angle units.
//   Reset clears all valid bits; no request is in flight afterwards.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   stall_o rises; bubbles do not hold it, so the pipeline keeps filling.
// ----------------------------------------------------------------------------
module accel_tilt_angles (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  atilt_pkg::sample_t sample_x_i,
  input  atilt_pkg::sample_t sample_y_i,
  input  atilt_pkg::sample_t sample_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output atilt_pkg::angle_t  pitch_angle_o,
  output atilt_pkg::angle_t  roll_angle_o,
  output atilt_pkg::angle_t  yaw_angle_o
);
  import atilt_pkg::*;

  logic [Latency-1:0] vld_q;
  logic [Latency-1:0] vld_d;
  logic               en;

  assign en      = !(vld_q[Latency-1] && stall_i);
  assign stall_o = !en;
  assign vld_d   = {vld_q[Latency-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  atilt_unit u_pitch (
    .clk_i, .en_i(en), .num_i(sample_x_i), .oth_a_i(sample_y_i),
    .oth_b_i(sample_z_i), .angle_o(pitch_angle_o)
  );

  atilt_unit u_roll (
    .clk_i, .en_i(en), .num_i(sample_y_i), .oth_a_i(sample_x_i),
    .oth_b_i(sample_z_i), .angle_o(roll_angle_o)
  );

  atilt_unit u_yaw (
    .clk_i, .en_i(en), .num_i(sample_z_i), .oth_a_i(sample_x_i),
    .oth_b_i(sample_y_i), .angle_o(yaw_angle_o)
  );

  assign valid_o = vld_q[Latency-1];

endmodule

### rtl/atilt_checker.sv
// ----------------------------------------------------------------------------
// atilt_checker
// Port-level checks on the tilt angle block, bound to the top level.
// ----------------------------------------------------------------------------
module atilt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              stall_o,
  input logic              valid_o,
  input logic              stall_i,
  input atilt_pkg::angle_t pitch_angle_o,
  input atilt_pkg::angle_t roll_angle_o,
  input atilt_pkg::angle_t yaw_angle_o
);
  import atilt_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(pitch_angle_o) &&
    $stable(roll_angle_o) && $stable(yaw_angle_o))
    else $error("stalled result changed");

  a_backpr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |-> stall_o)
    else $error("input taken while result stalled");

  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled with no result pending");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> pitch_angle_o <= RightAngle && pitch_angle_o >= -RightAngle &&
    roll_angle_o <= RightAngle && roll_angle_o >= -RightAngle &&
    yaw_angle_o <= RightAngle && yaw_angle_o >= -RightAngle)
    else $error("angle out of range");

endmodule

bind accel_tilt_angles atilt_checker u_atilt_checker (
  .clk_i, .rst_ni, .stall_o, .valid_o, .stall_i,
  .pitch_angle_o, .roll_angle_o, .yaw_angle_o
);
